FILE: hdl/rss_pkg.sv
// Shared constants and controller/datapath signal groups for the rectangle sum block.
package rss_pkg;

  localparam int CFG_DW = 7;
  localparam int CFG_IW = 1;

  localparam logic [CFG_IW-1:0] REG_ROWS = 1'b0;
  localparam logic [CFG_IW-1:0] REG_COLS = 1'b1;

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  localparam logic ST_OK  = 1'b0;
  localparam logic ST_OOB = 1'b1;

  typedef struct packed {
    logic load;
    logic clr;
    logic cell_rd;
    logic cell_wr;
    logic upd_wr;
    logic q_init;
    logic q_step;
    logic out_load;
  } rss_cmd_t;

  typedef struct packed {
    logic cfg_hit;
    logic clr_done;
    logic is_query;
    logic oob;
    logic upd_last;
    logic q_empty;
    logic q_last;
    logic out_free;
  } rss_sts_t;

endpackage

FILE: hdl/rss_if.sv
// Request and response channel interfaces.
interface rss_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [5:0]  row;
  logic [5:0]  col;
  logic signed [31:0] value;
  logic [5:0]  row_lo;
  logic [5:0]  row_hi;
  logic [5:0]  col_lo;
  logic [5:0]  col_hi;

  modport source (output valid, command, row, col, value, row_lo, row_hi, col_lo, col_hi,
                  input ready);
  modport sink (input valid, command, row, col, value, row_lo, row_hi, col_lo, col_hi,
                output ready);
endinterface

interface rss_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] sum;
  logic        status;

  modport source (output valid, sum, status, input ready);
  modport sink (input valid, sum, status, output ready);
endinterface

FILE: hdl/rss_ctrl.sv
// Sequencing state machine for clear, cell write, tree update and rectangle query.
module rss_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            req_valid_i,
  output logic            req_ready_o,
  input  rss_pkg::rss_sts_t sts_i,
  output rss_pkg::rss_cmd_t cmd_o
);
  import rss_pkg::*;

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CLEAR   = 4'd1;
  localparam logic [3:0] S_DISP    = 4'd2;
  localparam logic [3:0] S_CELL_RD = 4'd3;
  localparam logic [3:0] S_CELL_WR = 4'd4;
  localparam logic [3:0] S_UPD_RD  = 4'd5;
  localparam logic [3:0] S_UPD_WR  = 4'd6;
  localparam logic [3:0] S_Q_INIT  = 4'd7;
  localparam logic [3:0] S_Q_RUN   = 4'd8;
  localparam logic [3:0] S_Q_DRAIN = 4'd9;
  localparam logic [3:0] S_RESULT  = 4'd10;

  logic [3:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_DISP;
        end
      end
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_done) state_d = S_IDLE;
      end
      S_DISP: begin
        if (sts_i.is_query) state_d = S_Q_INIT;
        else if (sts_i.oob) state_d = S_RESULT;
        else state_d = S_CELL_RD;
      end
      S_CELL_RD: begin
        cmd_o.cell_rd = 1'b1;
        state_d       = S_CELL_WR;
      end
      S_CELL_WR: begin
        cmd_o.cell_wr = 1'b1;
        state_d       = S_UPD_RD;
      end
      S_UPD_RD: state_d = S_UPD_WR;
      S_UPD_WR: begin
        cmd_o.upd_wr = 1'b1;
        state_d      = sts_i.upd_last ? S_RESULT : S_UPD_RD;
      end
      S_Q_INIT: begin
        cmd_o.q_init = 1'b1;
        state_d      = sts_i.q_empty ? S_RESULT : S_Q_RUN;
      end
      S_Q_RUN: begin
        cmd_o.q_step = 1'b1;
        if (sts_i.q_last) state_d = S_Q_DRAIN;
      end
      S_Q_DRAIN: state_d = S_RESULT;
      S_RESULT: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (sts_i.cfg_hit) state_d = S_CLEAR;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_CLEAR;
    else state_q <= state_d;
  end

  assign req_ready_o = (state_q == S_IDLE) && !sts_i.cfg_hit;

endmodule

FILE: hdl/rss_datapath.sv
// Cell store, two-dimensional prefix tree store, index walkers and result register.
module rss_datapath #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  rss_pkg::rss_cmd_t          cmd_i,
  output rss_pkg::rss_sts_t          sts_o,
  input  logic                       cfg_we_i,
  input  logic [rss_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [rss_pkg::CFG_DW-1:0] cfg_data_i,
  input  logic                       command_i,
  input  logic [5:0]                 row_i,
  input  logic [5:0]                 col_i,
  input  logic signed [31:0]         value_i,
  input  logic [5:0]                 row_lo_i,
  input  logic [5:0]                 row_hi_i,
  input  logic [5:0]                 col_lo_i,
  input  logic [5:0]                 col_hi_i,
  input  logic                       out_ready_i,
  output logic                       out_valid_o,
  output logic signed [31:0]         out_sum_o,
  output logic                       out_status_o
);
  import rss_pkg::*;

  localparam int MAXD  = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
  localparam int IW    = $clog2(MAXD + 1) + 1;
  localparam int RA    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CA    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int AW    = RA + CA;
  localparam int DEPTH = 1 << AW;

  function automatic logic [IW-1:0] clamp_size(input logic [CFG_DW-1:0] v, input int mx);
    logic [IW-1:0] r;
    if (v == '0) r = IW'(1);
    else if (32'(v) > 32'(mx)) r = IW'(mx);
    else r = IW'(v);
    return r;
  endfunction

  function automatic logic [IW-1:0] lowbit(input logic [IW-1:0] x);
    return x & (~x + IW'(1));
  endfunction

  logic [IW-1:0] rows_q, cols_q;
  logic          cmd_q;
  logic [5:0]    row_q, col_q, rlo_q, rhi_q, clo_q, chi_q;
  logic [31:0]   val_q, delta_q, acc_q;
  logic [IW-1:0] i_q, j_q, rhi1_q, chi1_q;
  logic [1:0]    term_q;
  logic          rd_pend_q, neg_pend_q;
  logic [AW-1:0] clr_cnt_q;
  logic          out_vld_q, out_st_q;
  logic [31:0]   out_sum_q;
  logic [31:0]   cell_rd_q, fen_rd_q;
  logic [31:0]   cell_mem [DEPTH];
  logic [31:0]   fen_mem [DEPTH];

  logic [IW-1:0] rhi1, chi1, tb, ta_n, tb_n, jn, in_n, ju, iu, im1, jm1;
  logic [1:0]    term_n;
  logic          node_ok;
  logic [AW-1:0] fen_addr, cell_addr;
  logic          fen_we, cell_we;
  logic [31:0]   fen_wd, cell_wd;

  assign rhi1 = (32'(rhi_q) >= 32'(rows_q)) ? rows_q : IW'(rhi_q) + IW'(1);
  assign chi1 = (32'(chi_q) >= 32'(cols_q)) ? cols_q : IW'(chi_q) + IW'(1);

  assign term_n = term_q + 2'd1;
  assign tb     = term_q[1] ? IW'(clo_q) : chi1_q;
  assign ta_n   = term_n[0] ? IW'(rlo_q) : rhi1_q;
  assign tb_n   = term_n[1] ? IW'(clo_q) : chi1_q;

  assign node_ok = (i_q != '0) && (j_q != '0);
  assign jn      = j_q - lowbit(j_q);
  assign in_n    = i_q - lowbit(i_q);
  assign ju      = j_q + lowbit(j_q);
  assign iu      = i_q + lowbit(i_q);
  assign im1     = i_q - IW'(1);
  assign jm1     = j_q - IW'(1);

  assign sts_o.cfg_hit  = cfg_we_i && (cfg_idx_i == REG_ROWS || cfg_idx_i == REG_COLS);
  assign sts_o.clr_done = (clr_cnt_q == '1);
  assign sts_o.is_query = (cmd_q == CMD_QUERY);
  assign sts_o.oob      = (32'(row_q) >= 32'(rows_q)) || (32'(col_q) >= 32'(cols_q));
  assign sts_o.upd_last = (ju > cols_q) && (iu > rows_q);
  assign sts_o.q_empty  = (32'(rlo_q) >= 32'(rhi1)) || (32'(clo_q) >= 32'(chi1));
  assign sts_o.q_last   = (term_q == 2'd3) && (!node_ok || (jn == '0 && in_n == '0));
  assign sts_o.out_free = !out_vld_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rows_q <= clamp_size(CFG_DW'(64), MAX_ROWS);
      cols_q <= clamp_size(CFG_DW'(64), MAX_COLS);
    end else if (cfg_we_i) begin
      if (cfg_idx_i == REG_ROWS) rows_q <= clamp_size(cfg_data_i, MAX_ROWS);
      if (cfg_idx_i == REG_COLS) cols_q <= clamp_size(cfg_data_i, MAX_COLS);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_cnt_q <= '0;
    else if (sts_o.cfg_hit) clr_cnt_q <= '0;
    else if (cmd_i.clr) clr_cnt_q <= clr_cnt_q + AW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q <= command_i;
      row_q <= row_i;
      col_q <= col_i;
      val_q <= value_i;
      rlo_q <= row_lo_i;
      rhi_q <= row_hi_i;
      clo_q <= col_lo_i;
      chi_q <= col_hi_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.cell_wr) begin
      delta_q <= val_q - cell_rd_q;
      i_q     <= IW'(row_q) + IW'(1);
      j_q     <= IW'(col_q) + IW'(1);
    end else if (cmd_i.upd_wr) begin
      if (ju <= cols_q) begin
        j_q <= ju;
      end else begin
        i_q <= iu;
        j_q <= IW'(col_q) + IW'(1);
      end
    end else if (cmd_i.q_init) begin
      rhi1_q <= rhi1;
      chi1_q <= chi1;
      term_q <= 2'd0;
      i_q    <= rhi1;
      j_q    <= chi1;
    end else if (cmd_i.q_step) begin
      if (node_ok && jn != '0) begin
        j_q <= jn;
      end else if (node_ok && in_n != '0) begin
        i_q <= in_n;
        j_q <= tb;
      end else begin
        term_q <= term_n;
        i_q    <= ta_n;
        j_q    <= tb_n;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_pend_q <= 1'b0;
    end else begin
      rd_pend_q <= cmd_i.q_step && node_ok;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_pend_q <= ^term_q;
    if (cmd_i.q_init) acc_q <= '0;
    else if (rd_pend_q) acc_q <= neg_pend_q ? acc_q - fen_rd_q : acc_q + fen_rd_q;
  end

  assign fen_addr  = cmd_i.clr ? clr_cnt_q : {im1[RA-1:0], jm1[CA-1:0]};
  assign fen_we    = cmd_i.clr || cmd_i.upd_wr;
  assign fen_wd    = cmd_i.clr ? '0 : fen_rd_q + delta_q;
  assign cell_addr = cmd_i.clr ? clr_cnt_q : {RA'(row_q), CA'(col_q)};
  assign cell_we   = cmd_i.clr || cmd_i.cell_wr;
  assign cell_wd   = cmd_i.clr ? '0 : val_q;

  always_ff @(posedge clk_i) begin
    if (fen_we) fen_mem[fen_addr] <= fen_wd;
    fen_rd_q <= fen_mem[fen_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cell_we) cell_mem[cell_addr] <= cell_wd;
    if (cmd_i.cell_rd) cell_rd_q <= cell_mem[cell_addr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_sum_q <= (cmd_q == CMD_QUERY) ? acc_q : '0;
      out_st_q  <= (cmd_q == CMD_WRITE && sts_o.oob) ? ST_OOB : ST_OK;
    end
  end

  assign out_valid_o  = out_vld_q;
  assign out_sum_o    = out_sum_q;
  assign out_status_o = out_st_q;

endmodule

FILE: hdl/rect_sum_segment_tree_2d.sv
// Top level of the two-dimensional rectangle sum store.
//
// Requests arrive on req_i: command 0 sets cell (row, col) to value, command 1
// asks for the wrapped 32-bit sum over rows row_lo..row_hi by cols col_lo..col_hi,
// clipped to the grid in use. Each request gives one response on rsp_o, unless
// a size register write cuts it short: the sum (zero for a write) and status,
// set when a write lies outside the grid. Sums are kept in a two-dimensional
// prefix tree in a single-port memory next to a copy of the cells; each tree
// node costs one memory access in a query and a read and a write in an update.
// A write updates Lr*Lc tree nodes, Lr and Lc being the levels touched per axis,
// at most clog2(size)+1 each. A query visits each node of its four corner walks,
// at most clog2(size) levels per axis each. One request is in work at a time;
// req_i.ready is high only while the block is idle.
// Reset and every write of either size register clear both memories in one
// pass over all 2^(clog2(MAX_ROWS)+clog2(MAX_COLS)) addresses (4096 by default),
// during which no request is taken. A stalled response waits in the output
// register and the next request is already taken; its result is held until
// that slot frees.
module rect_sum_segment_tree_2d #(
  parameter int MAX_ROWS = 64,
  parameter int MAX_COLS = 64
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  rss_in_if.sink                     req_i,
  rss_out_if.source                  rsp_o,
  input  logic                       cfg_we_i,
  input  logic [rss_pkg::CFG_IW-1:0] cfg_idx_i,
  input  logic [rss_pkg::CFG_DW-1:0] cfg_data_i
);
  import rss_pkg::*;

  rss_cmd_t cmd;
  rss_sts_t sts;
  logic     req_ready;

  rss_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_i.valid),
    .req_ready_o (req_ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rss_datapath #(
    .MAX_ROWS (MAX_ROWS),
    .MAX_COLS (MAX_COLS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .command_i    (req_i.command),
    .row_i        (req_i.row),
    .col_i        (req_i.col),
    .value_i      (req_i.value),
    .row_lo_i     (req_i.row_lo),
    .row_hi_i     (req_i.row_hi),
    .col_lo_i     (req_i.col_lo),
    .col_hi_i     (req_i.col_hi),
    .out_ready_i  (rsp_o.ready),
    .out_valid_o  (rsp_o.valid),
    .out_sum_o    (rsp_o.sum),
    .out_status_o (rsp_o.status)
  );

  assign req_i.ready = req_ready;

  a_cfg_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_we_i |=> !req_i.ready)
    else $error("request taken during store clear");

  a_one_at_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.valid && req_i.ready |=> !req_i.ready)
    else $error("second request taken while one is in work");

  a_out_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.out_load |-> sts.out_free)
    else $error("result overwrote a pending response");

endmodule
